FILE: hw/rtl/mvf_pkg.sv
// ----------------------------------------------------------------------------
// mvf_pkg
// Shared widths, request kinds and defaults for the missing value finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mvf_pkg;

  localparam int KIND_W          = 2;
  localparam int VALUE_W         = 10;
  localparam int CURSOR_W        = VALUE_W + 1;
  localparam int IN_TDATA_W      = 16;
  localparam int OUT_TDATA_W     = 16;
  localparam int VALUE_RANGE_DEF = 1024;
  localparam int MAP_WORD_MAX    = 32;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

endpackage

FILE: hw/rtl/missing_value_finder_core.sv
// ----------------------------------------------------------------------------
// missing_value_finder_core
// Presence bitmap with running min/max; queries walk the bitmap word by word
// and return the next value between min and max that was never loaded.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata                  | tuser
//  --------+-----------+------------------------+-------------
//  in_     | slave     | [9:0] value            | [1:0] kind
//  out_    | master    | [9:0] missing_value    | [0] found
//
//  Load: read word, write word back. Clear: the row valid flags drop at
//  once, so no clearing pass is needed. Query: one bitmap word is walked
//  per read (at most 32 values per word), bounded by the single memory read
//  port; no-data queries skip the walk and go straight to the result.
//  One request is worked on at a time; a finished result sits in the output
//  register while further requests are taken. rst_n is synchronous.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module missing_value_finder_core
  import mvf_pkg::*;
#(
  parameter int VALUE_RANGE = VALUE_RANGE_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [9:0] value, rest zero
  input  logic [KIND_W-1:0]      in_tuser,   // [1:0] kind
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [9:0] missing_value, rest zero
  output logic                   out_tuser   // [0] found
);

  // values above the field width never arrive, so storage stops there
  localparam int ER  = (VALUE_RANGE < (2 ** VALUE_W)) ? VALUE_RANGE : (2 ** VALUE_W);
  localparam int W   = (ER >= MAP_WORD_MAX) ? MAP_WORD_MAX : (2 ** $clog2(ER));
  localparam int LB  = $clog2(W);
  localparam int NW  = (ER + W - 1) / W;
  localparam int WAW = (NW > 1) ? $clog2(NW) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic                  any_loaded_r, any_loaded_nxt;
  logic                  started_r, started_nxt;
  logic [VALUE_W-1:0]    low_r, low_nxt;
  logic [VALUE_W-1:0]    high_r, high_nxt;
  logic [CURSOR_W-1:0]   cur_r, cur_nxt;
  logic [NW-1:0]         row_vld_r, row_vld_nxt;
  logic [VALUE_W-1:0]    ld_val_r, ld_val_nxt;
  logic [VALUE_W-1:0]    res_val_r, res_val_nxt;
  logic                  res_found_r, res_found_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]    out_val_r, out_val_nxt;
  logic                  out_found_r, out_found_nxt;

  logic [W-1:0]          mem [NW];
  logic [W-1:0]          rd_data_r;
  logic                  rd_vld_r;
  logic                  rd_en, wr_en;
  logic [WAW-1:0]        rd_addr, wr_addr;
  logic [W-1:0]          wr_data;

  logic                  in_acc;
  logic [KIND_W-1:0]     in_kind;
  logic [VALUE_W-1:0]    in_val;
  logic                  in_val_ok;
  logic [CURSOR_W-1:0]   start_j;
  logic [W-1:0]          word_eff;
  logic [W-1:0]          cand;
  logic [LB-1:0]         hit_idx;
  logic                  hit;
  logic                  hi_same;
  logic [LB-1:0]         cur_off, hi_off, ld_off;
  logic [CURSOR_W-1:0]   word_base, hit_pos;

  assign in_kind   = in_tuser;
  assign in_val    = in_tdata[VALUE_W-1:0];
  assign in_val_ok = (32'(in_val) < VALUE_RANGE);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign start_j   = started_r ? cur_r : CURSOR_W'(low_r);
  assign word_eff  = rd_data_r & {W{rd_vld_r}};
  assign cur_off   = cur_r[LB-1:0];
  assign hi_off    = high_r[LB-1:0];
  assign ld_off    = ld_val_r[LB-1:0];
  assign hi_same   = ((CURSOR_W'(high_r) >> LB) == (cur_r >> LB));
  assign word_base = cur_r & ~CURSOR_W'(W - 1);
  assign hit_pos   = word_base | CURSOR_W'(hit_idx);

  // absent bits from the cursor up to the max, then first one of them
  always_comb begin
    cand    = '0;
    hit_idx = '0;
    for (int i = 0; i < W; i++) begin
      cand[i] = !word_eff[i] && (LB'(i) >= cur_off) && (!hi_same || (LB'(i) <= hi_off));
    end
    for (int i = W - 1; i >= 0; i--) begin
      if (cand[i]) hit_idx = LB'(i);
    end
    hit = |cand;
  end

  always_comb begin
    state_nxt      = state_r;
    any_loaded_nxt = any_loaded_r;
    started_nxt    = started_r;
    low_nxt        = low_r;
    high_nxt       = high_r;
    cur_nxt        = cur_r;
    row_vld_nxt    = row_vld_r;
    ld_val_nxt     = ld_val_r;
    res_val_nxt    = res_val_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_val_nxt    = out_val_r;
    out_found_nxt  = out_found_r;
    rd_en          = 1'b0;
    rd_addr        = WAW'(cur_r >> LB);
    wr_en          = 1'b0;
    wr_addr        = WAW'(ld_val_r >> LB);
    wr_data        = word_eff | (W'(1) << ld_off);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            KIND_LOAD: begin
              if (in_val_ok) begin
                ld_val_nxt     = in_val;
                rd_en          = 1'b1;
                rd_addr        = WAW'(in_val >> LB);
                any_loaded_nxt = 1'b1;
                started_nxt    = 1'b0;
                if (!any_loaded_r) begin
                  low_nxt  = in_val;
                  high_nxt = in_val;
                end else begin
                  if (in_val < low_r)  low_nxt  = in_val;
                  if (in_val > high_r) high_nxt = in_val;
                end
                state_nxt = S_LOAD;
              end
            end
            KIND_QUERY: begin
              res_val_nxt   = '0;
              res_found_nxt = 1'b0;
              if (!any_loaded_r) begin
                state_nxt = S_DONE;
              end else begin
                started_nxt = 1'b1;
                cur_nxt     = start_j;
                if (start_j > CURSOR_W'(high_r)) begin
                  state_nxt = S_DONE;
                end else begin
                  rd_en     = 1'b1;
                  rd_addr   = WAW'(start_j >> LB);
                  state_nxt = S_SCAN;
                end
              end
            end
            KIND_CLEAR: begin
              any_loaded_nxt = 1'b0;
              started_nxt    = 1'b0;
              low_nxt        = '0;
              high_nxt       = '0;
              cur_nxt        = '0;
              row_vld_nxt    = '0;
            end
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        wr_en                = 1'b1;
        row_vld_nxt[wr_addr] = 1'b1;
        state_nxt            = S_IDLE;
      end
      S_SCAN: begin
        if (hit) begin
          res_val_nxt   = hit_pos[VALUE_W-1:0];
          res_found_nxt = 1'b1;
          cur_nxt       = hit_pos + CURSOR_W'(1);
          state_nxt     = S_DONE;
        end else if (hi_same) begin
          cur_nxt   = CURSOR_W'(high_r) + CURSOR_W'(1);
          state_nxt = S_DONE;
        end else begin
          cur_nxt   = word_base + CURSOR_W'(W);
          rd_en     = 1'b1;
          rd_addr   = WAW'((word_base + CURSOR_W'(W)) >> LB);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_found_nxt = res_found_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= row_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      any_loaded_r <= 1'b0;
      started_r    <= 1'b0;
      low_r        <= '0;
      high_r       <= '0;
      cur_r        <= '0;
      row_vld_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      any_loaded_r <= any_loaded_nxt;
      started_r    <= started_nxt;
      low_r        <= low_nxt;
      high_r       <= high_nxt;
      cur_r        <= cur_nxt;
      row_vld_r    <= row_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ld_val_r    <= ld_val_nxt;
    res_val_r   <= res_val_nxt;
    res_found_r <= res_found_nxt;
    out_val_r   <= out_val_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_val_r);
  assign out_tuser  = out_found_r;

  // a clear request empties every bitmap row by the next cycle
  a_clear_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind == KIND_CLEAR) |=> (row_vld_r == '0))
    else $error("bitmap rows still valid after clear");

  // a word walk only runs on a non-empty set with the cursor inside min..max
  a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (any_loaded_r && cur_r <= CURSOR_W'(high_r)
                             && cur_r >= CURSOR_W'(low_r)))
    else $error("scan cursor outside loaded range");

  // a new result only enters the output register from the done state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result pushed outside done state");

  // a load write-back always follows a marked-present set
  a_load_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> (any_loaded_r && !started_r))
    else $error("load write-back without set update");

endmodule
